[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the calculator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication, sampled on clk and held off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

[hdl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// RPN calculator package
// Widths, command and status codes, and the stack cell command type.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ROT_W       = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [3:0] OP_PUSH  = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_PTOP  = 4'd5;
    localparam logic [3:0] OP_PALL  = 4'd6;
    localparam logic [3:0] OP_CLEAR = 4'd7;
    localparam logic [3:0] OP_ABS   = 4'd8;
    localparam logic [3:0] OP_NEG   = 4'd9;
    localparam logic [3:0] OP_DUP   = 4'd10;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_PRINT = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROT
    } cell_cmd_t;

endpackage

`default_nettype wire

[hdl/rpn_stack_calculator.sv]
// Push, print top, clear, abs, negate, dup and all errors strobe the result in the
// cycle after acceptance; add and sub pass S_WB first, mul S_MUL then S_WB, and div
// S_DIV until the divider is done, then S_WB. Print all strobes one word per cycle
// for the held entries and stays busy until all STACK_DEPTH cells rotate back into
// place. Commands are taken only in S_IDLE; one-bit-per-cycle division blocks them.
// Reset clears the stack count and control state; stack words hold no reset value.
// ----------------------------------------------------------------------------
// RPN stack calculator
// Command sequencer over a chain of stack cells with a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [3:0]                   operation,
    input  wire  [rsc_pkg::DATA_W-1:0]   operand_value,
    output logic                         done,
    output logic [rsc_pkg::DATA_W-1:0]   result_value,
    output logic [2:0]                   status,
    output logic                         last_result
);
    import rsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_WB,
        S_PALL
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ROT_W-1:0]  rot_reg;
    logic [ROT_W-1:0]  rot_next;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] res_next;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] x_next;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] y_next;
    logic              done_reg;
    logic              done_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [2:0]        status_reg;
    logic [2:0]        status_next;
    logic              last_reg;
    logic              last_next;

    cell_cmd_t         cell_cmd;
    logic [DATA_W-1:0] load_val;
    logic [DATA_W-1:0] cell_val [STACK_DEPTH];
    logic [DATA_W-1:0] top_val;
    logic [DATA_W-1:0] y_val;
    logic [2*DATA_W-1:0] prod;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic              accept;
    logic              empty;
    logic              full;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] above_w;
            logic [DATA_W-1:0] below_w;
            if (gi == 0)
            begin : g_head
                assign above_w = load_val;
            end
            else
            begin : g_body
                assign above_w = cell_val[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_tail
                assign below_w = cell_val[0];
            end
            else
            begin : g_link
                assign below_w = cell_val[gi+1];
            end
            rsc_cell u_cell (
                .clk     (clk),
                .cmd     (cell_cmd),
                .is_head (gi == 0),
                .above   (above_w),
                .below   (below_w),
                .value   (cell_val[gi])
            );
        end
    endgenerate

    assign top_val = cell_val[0];
    assign y_val   = (count_reg >= CNT_W'(2)) ? cell_val[1] : '0;
    assign accept  = start && (state_reg == S_IDLE);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign prod    = x_reg * y_reg;

    rsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (y_val),
        .divisor  (top_val),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rot_next    = rot_reg;
        res_next    = res_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        status_next = status_reg;
        last_next   = last_reg;
        cell_cmd    = CELL_HOLD;
        load_val    = top_val;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && operation <= OP_DUP)
                begin
                    done_next   = 1'b1;
                    last_next   = 1'b1;
                    value_next  = '0;
                    status_next = ST_DONE;
                    if (operation == OP_PUSH)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cell_cmd   = CELL_PUSH;
                            load_val   = operand_value;
                            count_next = count_reg + CNT_W'(1);
                            value_next = operand_value;
                        end
                    end
                    else if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        unique case (operation)
                            OP_ADD:
                            begin
                                done_next  = 1'b0;
                                res_next   = y_val + top_val;
                                state_next = S_WB;
                            end
                            OP_SUB:
                            begin
                                done_next  = 1'b0;
                                res_next   = y_val - top_val;
                                state_next = S_WB;
                            end
                            OP_MUL:
                            begin
                                done_next  = 1'b0;
                                x_next     = top_val;
                                y_next     = y_val;
                                state_next = S_MUL;
                            end
                            OP_DIV:
                            begin
                                if (top_val == '0)
                                begin
                                    status_next = ST_DIVZ;
                                end
                                else
                                begin
                                    done_next  = 1'b0;
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                            OP_PTOP:
                            begin
                                value_next  = top_val;
                                status_next = ST_PRINT;
                            end
                            OP_PALL:
                            begin
                                done_next  = 1'b0;
                                rot_next   = '0;
                                state_next = S_PALL;
                            end
                            OP_CLEAR:
                            begin
                                count_next = '0;
                            end
                            OP_ABS:
                            begin
                                cell_cmd   = CELL_LOAD;
                                load_val   = top_val[DATA_W-1] ?
                                             (DATA_W'(0) - top_val) : top_val;
                                value_next = load_val;
                            end
                            OP_NEG:
                            begin
                                cell_cmd   = CELL_LOAD;
                                load_val   = DATA_W'(0) - top_val;
                                value_next = load_val;
                            end
                            OP_DUP:
                            begin
                                if (full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    cell_cmd   = CELL_PUSH;
                                    load_val   = top_val;
                                    count_next = count_reg + CNT_W'(1);
                                    value_next = top_val;
                                end
                            end
                            default:
                            begin
                                done_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                res_next   = prod[DATA_W-1:0];
                state_next = S_WB;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cell_cmd    = CELL_POP;
                load_val    = res_reg;
                if (count_reg >= CNT_W'(2))
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                done_next   = 1'b1;
                last_next   = 1'b1;
                value_next  = res_reg;
                status_next = ST_DONE;
                state_next  = S_IDLE;
            end
            S_PALL:
            begin
                cell_cmd = CELL_ROT;
                if ({1'b0, rot_reg} < (ROT_W+1)'(count_reg))
                begin
                    done_next   = 1'b1;
                    value_next  = top_val;
                    status_next = ST_PRINT;
                    last_next   = ({1'b0, rot_reg} == (ROT_W+1)'(count_reg - CNT_W'(1)));
                end
                rot_next = rot_reg + ROT_W'(1);
                if (rot_reg == ROT_W'(STACK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rot_reg    <= '0;
            done_reg   <= 1'b0;
            value_reg  <= '0;
            status_reg <= ST_DONE;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rot_reg    <= rot_next;
            done_reg   <= done_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign last_result  = last_reg;

endmodule

`default_nettype wire

[hdl/rsc_cell.sv]
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stack word and moves it toward either neighbor on command.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_cell (
    input  wire                          clk,
    input  wire rsc_pkg::cell_cmd_t      cmd,
    input  wire                          is_head,
    input  wire  [rsc_pkg::DATA_W-1:0]   above,
    input  wire  [rsc_pkg::DATA_W-1:0]   below,
    output logic [rsc_pkg::DATA_W-1:0]   value
);
    import rsc_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        unique case (cmd)
            CELL_HOLD: value_next = value_reg;
            CELL_LOAD: value_next = is_head ? above : value_reg;
            CELL_PUSH: value_next = above;
            CELL_POP:  value_next = is_head ? above : below;
            CELL_ROT:  value_next = below;
            default:   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

[hdl/rsc_divider.sv]
// ----------------------------------------------------------------------------
// Signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_divider (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  [rsc_pkg::DATA_W-1:0]   dividend,
    input  wire  [rsc_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [rsc_pkg::DATA_W-1:0]   quotient
);
    import rsc_pkg::*;

    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DATA_W-1:0]    den_reg;
    logic [DATA_W-1:0]    den_next;
    logic                 neg_reg;
    logic                 neg_next;

    logic [DATA_W:0]      rem_sh;
    logic [DATA_W+1:0]    diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            den_next = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

[hdl/rsc_checker.sv]
// ----------------------------------------------------------------------------
// RPN calculator checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsc_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire  [3:0]                   operation,
    input wire  [rsc_pkg::DATA_W-1:0]   operand_value,
    input wire                          done,
    input wire  [rsc_pkg::DATA_W-1:0]   result_value,
    input wire  [2:0]                   status,
    input wire                          last_result
);
    import rsc_pkg::*;

    `ASSERT_NEXT(a_ptop_next, start && !busy && operation == OP_PTOP, done && last_result && (status == ST_PRINT || status == ST_EMPTY))
    `ASSERT_NEXT(a_push_next, start && !busy && operation == OP_PUSH, done && last_result && ((status == ST_DONE && result_value == $past(operand_value)) || status == ST_FULL))
    `ASSERT_NEXT(a_pall_burst, done && !last_result, done && status == ST_PRINT)
    `ASSERT_IMPL(a_err_zero, done && (status == ST_EMPTY || status == ST_FULL || status == ST_DIVZ), result_value == '0)
    `ASSERT_IMPL(a_single_word, done && status != ST_PRINT, last_result)

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .operand_value (operand_value),
    .done          (done),
    .result_value  (result_value),
    .status        (status),
    .last_result   (last_result)
);

`default_nettype wire
